>>> sv/nsc_pkg.sv
package nsc_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] CharG      = 8'h47;
  localparam logic [7:0] CharA      = 8'h41;
  localparam logic [7:0] CharR      = 8'h52;
  localparam logic [7:0] CharM      = 8'h4D;
  localparam logic [7:0] CharC      = 8'h43;
  localparam logic [7:0] CharZ      = 8'h5A;
  localparam logic [7:0] CharD      = 8'h44;
  localparam logic [7:0] CharP      = 8'h50;
  localparam logic [7:0] CharN      = 8'h4E;

  localparam logic [4:0] LenMax      = 5'd31;
  localparam logic [3:0] CommaNone   = 4'd15;
  localparam logic [3:0] CommaAddr   = 4'd6;
  localparam logic [4:0] LenMin      = 5'd4;
  localparam logic [4:0] LenGgaProbe = 5'd6;
  localparam logic [4:0] LenNoComma  = 5'd9;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_FRAME_FAIL = 3'd1,
    STATUS_ADDR_LEN   = 3'd2,
    STATUS_TYPE_OTHER = 3'd3,
    STATUS_TALKER     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TYPE_GGA   = 2'd0,
    TYPE_RMC   = 2'd1,
    TYPE_ZDA   = 2'd2,
    TYPE_OTHER = 2'd3
  } sentence_type_t;

  // Everything the back end needs to judge one finished line.
  typedef struct packed {
    logic [3:0][7:0] recent_bytes;
    logic [7:0]      xor_running;
    logic [4:0]      line_length;
    logic            non_ascii_seen;
    logic            first_is_dollar;
    logic [4:0][7:0] address_chars;
    logic [3:0]      first_comma_index;
  } line_snap_t;

endpackage

>>> sv/nsc_in_if.sv
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> sv/nsc_out_if.sv
interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] sentence_type;
  logic       talker_gn;
  logic       gga_dropped;
  logic [7:0] computed_checksum;

  modport source (output valid, output status, output sentence_type, output talker_gn,
                  output gga_dropped, output computed_checksum, input ready);
  modport sink (input valid, input status, input sentence_type, input talker_gn,
                input gga_dropped, input computed_checksum, output ready);
endinterface

>>> sv/nsc_front.sv
module nsc_front (
  input  logic                clk,
  input  logic                rst,
  nsc_in_if.sink              bytes,
  input  logic                queue_full,
  output logic                push,
  output nsc_pkg::line_snap_t push_data
);

  nsc_pkg::line_snap_t line;
  nsc_pkg::line_snap_t line_next;
  nsc_pkg::line_snap_t line_clear;
  logic                accept;
  logic                line_end;
  logic [7:0]          b;
  logic [4:0]          idx;

  assign bytes.ready = !queue_full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.data_byte;
  assign idx         = line.line_length;

  always_comb begin
    line_clear                   = '0;
    line_clear.first_comma_index = nsc_pkg::CommaNone;
  end

  assign line_end = bytes.end_of_stream ? (line.line_length != 5'd0) : (b == nsc_pkg::CharLf);
  assign push      = accept && line_end;
  assign push_data = line;

  always_comb begin
    line_next = line;
    if (bytes.end_of_stream || b == nsc_pkg::CharLf) begin
      line_next = line_clear;
    end else begin
      if (idx == 5'd0) begin
        line_next.first_is_dollar = (b == nsc_pkg::CharDollar);
      end else begin
        line_next.xor_running = line.xor_running ^ b;
        for (int i = 0; i < 5; i++) begin
          if (idx == 5'(i + 1)) begin
            line_next.address_chars[i] = b;
          end
        end
        if (b == nsc_pkg::CharComma && line.first_comma_index == nsc_pkg::CommaNone &&
            idx < 5'd15) begin
          line_next.first_comma_index = idx[3:0];
        end
      end
      if (b > nsc_pkg::AsciiMax) begin
        line_next.non_ascii_seen = 1'b1;
      end
      line_next.recent_bytes = {b, line.recent_bytes[3:1]};
      if (line.line_length < nsc_pkg::LenMax) begin
        line_next.line_length = line.line_length + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= line_clear;
    end else if (accept) begin
      line <= line_next;
    end
  end

endmodule

>>> sv/nsc_queue.sv
module nsc_queue #(
  parameter int unsigned Depth = nsc_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nsc_pkg::line_snap_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output nsc_pkg::line_snap_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nsc_pkg::line_snap_t entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/nsc_back.sv
module nsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  nsc_pkg::line_snap_t head,
  output logic                pop,
  nsc_out_if.source           results
);

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  logic                    cr;
  logic [4:0]              n;
  logic [7:0]              c0;
  logic [7:0]              c1;
  logic [7:0]              c2;
  logic [7:0]              sum;
  logic [4:0]              hi;
  logic [4:0]              lo;
  logic                    ok;
  logic                    addr_ok;
  logic                    gp;
  logic                    gn;
  logic                    is_gga;
  nsc_pkg::status_t        status;
  nsc_pkg::sentence_type_t stype;
  logic                    dropped;

  always_comb begin
    cr = (head.line_length != 5'd0) && (head.recent_bytes[3] == nsc_pkg::CharCr);
    n  = cr ? head.line_length - 5'd1 : head.line_length;
    if (cr) begin
      c0 = head.recent_bytes[0];
      c1 = head.recent_bytes[1];
      c2 = head.recent_bytes[2];
    end else begin
      c0 = head.recent_bytes[1];
      c1 = head.recent_bytes[2];
      c2 = head.recent_bytes[3];
    end
    sum = '0;
    if (n >= nsc_pkg::LenMin) begin
      sum = head.xor_running ^ c0 ^ c1 ^ c2 ^ (cr ? nsc_pkg::CharCr : 8'h00);
    end
    hi = hex_value(c1);
    lo = hex_value(c2);
    ok = (n >= nsc_pkg::LenMin) && head.first_is_dollar && (c0 == nsc_pkg::CharStar) &&
         !head.non_ascii_seen && !hi[4] && !lo[4] && (sum == {hi[3:0], lo[3:0]});
    addr_ok = (head.first_comma_index == nsc_pkg::CommaAddr) ||
              (head.first_comma_index == nsc_pkg::CommaNone && n == nsc_pkg::LenNoComma);
    gp = (head.address_chars[0] == nsc_pkg::CharG) && (head.address_chars[1] == nsc_pkg::CharP);
    gn = (head.address_chars[0] == nsc_pkg::CharG) && (head.address_chars[1] == nsc_pkg::CharN);
    is_gga = (head.address_chars[2] == nsc_pkg::CharG) &&
             (head.address_chars[3] == nsc_pkg::CharG) &&
             (head.address_chars[4] == nsc_pkg::CharA);

    stype = nsc_pkg::TYPE_OTHER;
    if (is_gga) begin
      stype = nsc_pkg::TYPE_GGA;
    end else if (head.address_chars[2] == nsc_pkg::CharR &&
                 head.address_chars[3] == nsc_pkg::CharM &&
                 head.address_chars[4] == nsc_pkg::CharC) begin
      stype = nsc_pkg::TYPE_RMC;
    end else if (head.address_chars[2] == nsc_pkg::CharZ &&
                 head.address_chars[3] == nsc_pkg::CharD &&
                 head.address_chars[4] == nsc_pkg::CharA) begin
      stype = nsc_pkg::TYPE_ZDA;
    end

    dropped = 1'b0;
    if (!ok) begin
      status  = nsc_pkg::STATUS_FRAME_FAIL;
      stype   = nsc_pkg::TYPE_OTHER;
      gn      = 1'b0;
      dropped = (n >= nsc_pkg::LenGgaProbe) && head.first_is_dollar && is_gga;
    end else if (!addr_ok) begin
      status = nsc_pkg::STATUS_ADDR_LEN;
      stype  = nsc_pkg::TYPE_OTHER;
      gn     = 1'b0;
    end else if (stype == nsc_pkg::TYPE_OTHER) begin
      status = nsc_pkg::STATUS_TYPE_OTHER;
    end else if (!gp && !gn) begin
      status  = nsc_pkg::STATUS_TALKER;
      dropped = (stype == nsc_pkg::TYPE_GGA);
    end else begin
      status = nsc_pkg::STATUS_OK;
    end
  end

  assign pop = head_valid && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.status            <= status;
      results.sentence_type     <= stype;
      results.talker_gn         <= gn;
      results.gga_dropped       <= dropped;
      results.computed_checksum <= sum;
    end
  end

endmodule

>>> sv/nmea_sentence_checker_top.sv
// Channel   Role     Payload
// bytes     sink     data_byte[7:0], end_of_stream
// results   source   status[2:0], sentence_type[1:0], talker_gn, gga_dropped,
//                    computed_checksum[7:0]
//
// One byte is taken every cycle unless the queue is full; line ends go via the queue to results.
// The front end updates the line state once for each accepted byte.
// Finished lines wait in a queue of QueueDepth entries, so the byte side only stalls
// when that queue is full.
// Synchronous reset clears the line state, the queue and the results valid flag.
module nmea_sentence_checker_top #(
  parameter int unsigned QueueDepth = nsc_pkg::QueueDepthDefault
) (
  input logic        clk,
  input logic        rst,
  nsc_in_if.sink     bytes,
  nsc_out_if.source  results
);

  logic                queue_full;
  logic                push;
  nsc_pkg::line_snap_t push_data;
  logic                pop;
  logic                head_valid;
  nsc_pkg::line_snap_t head;

  nsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  nsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  nsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_q_t[$];

  typedef struct {
    nsc_pkg::status_t        status;
    nsc_pkg::sentence_type_t kind;
    logic                    gn;
    logic                    dropped;
    logic [7:0]              sum;
  } verdict_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 200;
  localparam int unsigned HoldOff     = 300;
  localparam int unsigned AddrChars   = 5;

  logic clk;
  logic rst;

  nsc_in_if  bytes_if ();
  nsc_out_if results_if ();

  nmea_sentence_checker_top dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (results_if)
  );

  // Line state of the predictor.
  logic [3:0][7:0] line_tail;
  logic [7:0]      line_xor;
  logic [4:0]      line_len;
  logic            line_high_seen;
  logic            line_dollar;
  logic [4:0][7:0] line_addr;
  logic [3:0]      line_comma;

  verdict_t    expected_verdicts[$];
  int unsigned mismatches = 0;
  int unsigned lines_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_cycles = 0;
  bit          steady = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** nmea_sentence_checker_top: FAILED **");
      $finish;
    end
  end

  function automatic void append_octet(ref octet_q_t q, input logic [7:0] b);
    q = {q, b};
  endfunction

  function automatic void clear_line();
    line_tail      = '0;
    line_xor       = '0;
    line_len       = '0;
    line_high_seen = 1'b0;
    line_dollar    = 1'b0;
    line_addr      = '0;
    line_comma     = nsc_pkg::CommaNone;
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void judge_line();
    int unsigned n;
    bit          cr;
    bit          ok;
    bit          gp;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    int          hi;
    int          lo;
    verdict_t    v;
    n = line_len;
    cr = (n >= 1) && (line_tail[3] == nsc_pkg::CharCr);
    v.status  = nsc_pkg::STATUS_FRAME_FAIL;
    v.kind    = nsc_pkg::TYPE_OTHER;
    v.gn      = 1'b0;
    v.dropped = 1'b0;
    v.sum     = '0;
    if (cr) begin
      n--;
      c0 = line_tail[0];
      c1 = line_tail[1];
      c2 = line_tail[2];
    end else begin
      c0 = line_tail[1];
      c1 = line_tail[2];
      c2 = line_tail[3];
    end
    if (n >= nsc_pkg::LenMin)
      v.sum = line_xor ^ c0 ^ c1 ^ c2 ^ (cr ? nsc_pkg::CharCr : 8'h00);
    ok = (n >= nsc_pkg::LenMin) && line_dollar && (c0 == nsc_pkg::CharStar) &&
         !line_high_seen;
    if (ok) begin
      hi = digit_value(c1);
      lo = digit_value(c2);
      ok = (hi >= 0) && (lo >= 0) && (v.sum == 8'(hi * 16 + lo));
    end
    if (!ok) begin
      v.dropped = (n >= nsc_pkg::LenGgaProbe) && line_dollar &&
                  line_addr[2] == nsc_pkg::CharG && line_addr[3] == nsc_pkg::CharG &&
                  line_addr[4] == nsc_pkg::CharA;
    end else if (!(line_comma == nsc_pkg::CommaAddr ||
                   (line_comma == nsc_pkg::CommaNone && n == nsc_pkg::LenNoComma))) begin
      v.status = nsc_pkg::STATUS_ADDR_LEN;
    end else begin
      gp   = line_addr[0] == nsc_pkg::CharG && line_addr[1] == nsc_pkg::CharP;
      v.gn = line_addr[0] == nsc_pkg::CharG && line_addr[1] == nsc_pkg::CharN;
      if (line_addr[2] == nsc_pkg::CharG && line_addr[3] == nsc_pkg::CharG &&
          line_addr[4] == nsc_pkg::CharA) begin
        v.kind = nsc_pkg::TYPE_GGA;
      end else if (line_addr[2] == nsc_pkg::CharR && line_addr[3] == nsc_pkg::CharM &&
                   line_addr[4] == nsc_pkg::CharC) begin
        v.kind = nsc_pkg::TYPE_RMC;
      end else if (line_addr[2] == nsc_pkg::CharZ && line_addr[3] == nsc_pkg::CharD &&
                   line_addr[4] == nsc_pkg::CharA) begin
        v.kind = nsc_pkg::TYPE_ZDA;
      end
      if (v.kind == nsc_pkg::TYPE_OTHER) begin
        v.status = nsc_pkg::STATUS_TYPE_OTHER;
      end else if (!gp && !v.gn) begin
        v.status  = nsc_pkg::STATUS_TALKER;
        v.dropped = (v.kind == nsc_pkg::TYPE_GGA);
      end else begin
        v.status = nsc_pkg::STATUS_OK;
      end
    end
    expected_verdicts = {expected_verdicts, v};
    clear_line();
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic eos);
    if (eos) begin
      if (line_len != 0) judge_line();
    end else if (b == nsc_pkg::CharLf) begin
      judge_line();
    end else begin
      if (line_len == 0) begin
        line_dollar = (b == nsc_pkg::CharDollar);
      end else begin
        line_xor ^= b;
        if (line_len <= AddrChars) line_addr[line_len - 1] = b;
        if (b == nsc_pkg::CharComma && line_comma == nsc_pkg::CommaNone &&
            line_len < 5'(nsc_pkg::CommaNone)) begin
          line_comma = line_len[3:0];
        end
      end
      if (b > nsc_pkg::AsciiMax) line_high_seen = 1'b1;
      line_tail = {b, line_tail[3:1]};
      if (line_len < nsc_pkg::LenMax) line_len++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("mismatch: %s", what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result arrived with no line pending");
      end else begin
        want = expected_verdicts.pop_front();
        lines_checked++;
        if (results_if.status !== want.status)
          report_mismatch($sformatf("line %0d status %0d, want %0d",
                                    lines_checked, results_if.status, want.status));
        if (results_if.sentence_type !== want.kind)
          report_mismatch($sformatf("line %0d sentence_type %0d, want %0d",
                                    lines_checked, results_if.sentence_type, want.kind));
        if (results_if.talker_gn !== want.gn)
          report_mismatch($sformatf("line %0d talker_gn %0b, want %0b",
                                    lines_checked, results_if.talker_gn, want.gn));
        if (results_if.gga_dropped !== want.dropped)
          report_mismatch($sformatf("line %0d gga_dropped %0b, want %0b",
                                    lines_checked, results_if.gga_dropped, want.dropped));
        if (results_if.computed_checksum !== want.sum)
          report_mismatch($sformatf("line %0d computed_checksum %02h, want %02h",
                                    lines_checked, results_if.computed_checksum, want.sum));
      end
    end
  end

  // A requested hold-off in hold_off_cycles keeps ready low before ready is driven again.
  initial begin : drive_result_ready
    int unsigned held;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        held = hold_off_cycles;
        hold_off_cycles = 0;
        results_if.ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      results_if.ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_request(input logic [7:0] b, input logic eos);
    if (!steady && $urandom_range(99) < 27) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid         <= 1'b1;
    bytes_if.data_byte     <= b;
    bytes_if.end_of_stream <= eos;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    track_byte(b, eos);
    if (!eos) bytes_sent++;
  endtask

  task automatic send_bytes(input octet_q_t q);
    foreach (q[i]) send_request(q[i], 1'b0);
  endtask

  function automatic void add_text(ref octet_q_t q, input string s);
    foreach (s[i]) append_octet(q, 8'(s[i]));
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'("0" + v);
    return 8'((lower ? "a" : "A") + v - 10);
  endfunction

  function automatic void frame_sentence(ref octet_q_t line, input octet_q_t body,
                                         input bit lower, input bit corrupt);
    logic [7:0] sum;
    sum = '0;
    append_octet(line, nsc_pkg::CharDollar);
    foreach (body[i]) begin
      append_octet(line, body[i]);
      sum ^= body[i];
    end
    if (corrupt) sum ^= 8'h01 << $urandom_range(7);
    append_octet(line, nsc_pkg::CharStar);
    append_octet(line, hex_glyph(sum[7:4], lower));
    append_octet(line, hex_glyph(sum[3:0], lower));
  endfunction

  task automatic send_body(input octet_q_t body, input bit lower, input bit with_cr,
                           input bit corrupt);
    octet_q_t line;
    frame_sentence(line, body, lower, corrupt);
    if (with_cr) append_octet(line, nsc_pkg::CharCr);
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
  endtask

  task automatic send_nmea(input string text, input bit lower, input bit with_cr);
    octet_q_t body;
    add_text(body, text);
    send_body(body, lower, with_cr, 1'b0);
  endtask

  task automatic send_random_line();
    octet_q_t    body;
    octet_q_t    line;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      repeat ($urandom_range(20)) append_octet(line, 8'($urandom_range(255)));
      append_octet(line, nsc_pkg::CharLf);
      send_bytes(line);
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) add_text(body, "GP");
      else if (pick < 75) add_text(body, "GN");
      else repeat (2) append_octet(body, 8'($urandom_range(90, 65)));
      pick = $urandom_range(99);
      if (pick < 30) add_text(body, "GGA");
      else if (pick < 55) add_text(body, "RMC");
      else if (pick < 80) add_text(body, "ZDA");
      else repeat (3) append_octet(body, 8'($urandom_range(90, 65)));
      pick = $urandom_range(99);
      if (pick < 5) body.delete(body.size() - 1);
      else if (pick < 10)
        repeat ($urandom_range(3, 1)) append_octet(body, 8'($urandom_range(90, 65)));
      if ($urandom_range(9) != 0) begin
        append_octet(body, nsc_pkg::CharComma);
        repeat ($urandom_range(24)) append_octet(body, 8'($urandom_range(126, 32)));
      end
      frame_sentence(line, body, 1'($urandom_range(1)), $urandom_range(9) == 0);
      if ($urandom_range(24) == 0) line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 45) begin
        append_octet(line, nsc_pkg::CharCr);
        append_octet(line, nsc_pkg::CharLf);
      end else if (pick < 85) begin
        append_octet(line, nsc_pkg::CharLf);
      end
      send_bytes(line);
      if (pick >= 85 && pick < 95) send_request(8'($urandom_range(255)), 1'b1);
    end
    if ($urandom_range(29) == 0) send_request(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_line_framing();
    octet_q_t body;
    octet_q_t line;
    send_request(nsc_pkg::CharLf, 1'b0);
    send_request(8'hFF, 1'b1);
    add_text(line, "ab");
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
    line.delete();
    add_text(line, "$*0");
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
    line.delete();
    add_text(line, "$*00");
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
    line.delete();
    add_text(body, "GPGGA,1");
    frame_sentence(line, body, 1'b0, 1'b0);
    line[0] = "X";
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
    body.delete();
    add_text(body, "GPGGA,2");
    send_body(body, 1'b0, 1'b1, 1'b1);
    line.delete();
    add_text(line, "$GPGGA,1*G1");
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
    body.delete();
    add_text(body, "GPRMC,");
    append_octet(body, 8'h00);
    append_octet(body, nsc_pkg::CharComma);
    send_body(body, 1'b0, 1'b0, 1'b0);
    body.delete();
    add_text(body, "GPRMC,");
    append_octet(body, 8'h80);
    append_octet(body, 8'hFF);
    send_body(body, 1'b1, 1'b0, 1'b0);
    body.delete();
    line.delete();
    add_text(body, "GPZDA,1");
    frame_sentence(line, body, 1'b0, 1'b0);
    append_octet(line, nsc_pkg::CharCr);
    append_octet(line, nsc_pkg::CharCr);
    append_octet(line, nsc_pkg::CharLf);
    send_bytes(line);
    body.delete();
    add_text(body, "GPGGA,1");
    append_octet(body, nsc_pkg::CharCr);
    add_text(body, "2");
    send_body(body, 1'b0, 1'b1, 1'b0);
    body.delete();
    line.delete();
    add_text(body, "GNRMC,9");
    frame_sentence(line, body, 1'b1, 1'b0);
    send_bytes(line);
    send_request(8'h00, 1'b1);
    send_request(8'h5A, 1'b1);
    append_octet(line, nsc_pkg::CharCr);
    send_bytes(line);
    send_request(8'hFF, 1'b1);
  endtask

  task automatic test_address_rules();
    send_nmea("GPGGA,123519,4807.038,N", 1'b0, 1'b1);
    send_nmea("GNRMC,1,A", 1'b1, 1'b0);
    send_nmea("GPZDA,2", 1'b0, 1'b0);
    send_nmea("GNGGA,7", 1'b0, 1'b1);
    send_nmea("GPGSV,3", 1'b0, 1'b1);
    send_nmea("BDGGA,1", 1'b0, 1'b0);
    send_nmea("BDRMC,1", 1'b1, 1'b0);
    send_nmea("GNGGAX,1", 1'b0, 1'b0);
    send_nmea("GPGGA", 1'b0, 1'b0);
    send_nmea("GPGG", 1'b0, 1'b0);
    send_nmea("GPGGA,0123456789012345678901234", 1'b0, 1'b1);
    send_nmea("GPGGAXXXXXXXXXXX,1", 1'b0, 1'b0);
    send_nmea("GNZDA,", 1'b1, 1'b1);
  endtask

  task automatic test_result_backpressure();
    hold_off_cycles = HoldOff;
    repeat (6) send_random_line();
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (6) send_random_line();
    steady = 1'b0;
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) send_random_line();
  endtask

  initial begin
    rst                    <= 1'b1;
    bytes_if.valid         <= 1'b0;
    bytes_if.data_byte     <= '0;
    bytes_if.end_of_stream <= 1'b0;
    clear_line();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_line_framing();
    test_address_rules();
    test_result_backpressure();
    test_steady_stream();
    test_random_stream();
    bytes_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** nmea_sentence_checker_top: PASSED **");
    end else begin
      $display("** nmea_sentence_checker_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/nsc_pkg.sv
sv/nsc_in_if.sv
sv/nsc_out_if.sv
sv/nsc_front.sv
sv/nsc_queue.sv
sv/nsc_back.sv
sv/nmea_sentence_checker_top.sv
verif/tb_top.sv
